### hw/rtl/fdc_pkg.sv
// shared types and constants of the fiber direction colorizer
// depends on nothing; imported by fdc_ctrl, fdc_dp and the top level
package fdc_pkg;

    localparam int FDC_COORD_WIDTH     = 20;
    localparam int FDC_COLOR_FRAC_BITS = 15;
    // differences are scaled down until every component is below 2^30
    localparam int FDC_MAG_LIMIT       = 30;

    // points held of the open fiber
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_MANY = 2'd2;

    // which color a pass of the arithmetic produces
    typedef enum logic [1:0] {
        JOB_FWD   = 2'd0,  // pending vertex, now that its successor is known
        JOB_END   = 2'd1,  // last vertex of the fiber
        JOB_FIBER = 2'd2   // whole-fiber global color
    } fdc_job_t;

    typedef struct packed {
        logic       accept;
        fdc_job_t   job;
        logic       res_last;
        logic       diff;
        logic       shift;
        logic       sq_step;
        logic [1:0] sq_sel;
        logic       rt_init;
        logic       rt_step;
        logic       dv_init;
        logic       dv_step;
        logic       emit;
        logic       finish;
    } fdc_cmd_t;

    typedef struct packed {
        logic seen_zero;
        logic big;
        logic out_free;
    } fdc_stat_t;

endpackage

### hw/rtl/fdc_ctrl.sv
// sequencer of the fiber direction colorizer
// depends on fdc_pkg; drives fdc_dp through fdc_cmd_t and reads fdc_stat_t
module fdc_ctrl
    import fdc_pkg::*;
#(
    parameter int COORD_WIDTH     = FDC_COORD_WIDTH,
    parameter int COLOR_FRAC_BITS = FDC_COLOR_FRAC_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      first_point,
    input  logic      last_point,
    output logic      in_stall,
    input  fdc_stat_t stat,
    output fdc_cmd_t  cmd
);

    localparam int SW   = (COORD_WIDTH > FDC_MAG_LIMIT) ? FDC_MAG_LIMIT : COORD_WIDTH;
    localparam int RW   = SW + 1;
    localparam int F    = COLOR_FRAC_BITS;
    localparam int MAXC = (RW > F + 1) ? RW : F + 1;
    localparam int CNTW = $clog2(MAXC);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_DIFF    = 8'b0000_0010,
        ST_SHIFT   = 8'b0000_0100,
        ST_SQUARE  = 8'b0000_1000,
        ST_SQRT    = 8'b0001_0000,
        ST_DIVINIT = 8'b0010_0000,
        ST_DIV     = 8'b0100_0000,
        ST_EMIT    = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    fdc_job_t          job_reg, job_next;
    logic              last_reg, last_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.job    = job_reg;
        unique case (job_reg)
            JOB_FWD:   cmd.res_last = !last_reg;
            JOB_END:   cmd.res_last = 1'b0;
            JOB_FIBER: cmd.res_last = 1'b1;
            default:   cmd.res_last = 1'b1;
        endcase
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    last_next  = last_point;
                    job_next   = JOB_FWD;
                    if (!first_point && !stat.seen_zero)
                        state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (stat.big)
                    cmd.shift = 1'b1;
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.sq_step = 1'b1;
                cmd.sq_sel  = cnt_reg[1:0];
                if (cnt_reg == CNTW'(2))
                begin
                    cmd.rt_init = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_SQRT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SQRT:
            begin
                cmd.rt_step = 1'b1;
                if (cnt_reg == CNTW'(RW - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIVINIT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DIVINIT:
            begin
                cmd.dv_init = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.dv_step = 1'b1;
                if (cnt_reg == CNTW'(F))
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    unique case (job_reg)
                        JOB_FWD:
                        begin
                            if (last_reg)
                            begin
                                job_next   = JOB_END;
                                state_next = ST_DIFF;
                            end
                            else
                            begin
                                cmd.finish = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        JOB_END:
                        begin
                            job_next   = JOB_FIBER;
                            state_next = ST_DIFF;
                        end
                        default:
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_FWD;
            last_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            last_reg  <= last_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### hw/rtl/fdc_dp.sv
// datapath of the fiber direction colorizer: fiber points, difference,
// sum of squares, digit-serial square root, three divider lanes, output register
// depends on fdc_pkg; commanded by fdc_ctrl
module fdc_dp
    import fdc_pkg::*;
#(
    parameter int COORD_WIDTH     = FDC_COORD_WIDTH,
    parameter int COLOR_FRAC_BITS = FDC_COLOR_FRAC_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [COORD_WIDTH-1:0]     x,
    input  logic signed [COORD_WIDTH-1:0]     y,
    input  logic signed [COORD_WIDTH-1:0]     z,
    input  logic                              first_point,
    input  logic                              last_point,
    input  fdc_cmd_t                          cmd,
    output fdc_stat_t                         stat,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic                              kind,
    output logic signed [COORD_WIDTH-1:0]     pos_x,
    output logic signed [COORD_WIDTH-1:0]     pos_y,
    output logic signed [COORD_WIDTH-1:0]     pos_z,
    output logic        [COLOR_FRAC_BITS:0]   red,
    output logic        [COLOR_FRAC_BITS:0]   green,
    output logic        [COLOR_FRAC_BITS:0]   blue,
    output logic                              last
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = COLOR_FRAC_BITS;
    localparam int SW  = (CW > FDC_MAG_LIMIT) ? FDC_MAG_LIMIT : CW;
    localparam int SSW = 2 * SW + 2;
    localparam int RW  = SW + 1;
    localparam int RMW = RW + 2;
    localparam int NW  = SW + F + 1;
    localparam int DRW = RW + 1;
    localparam logic [F:0] COLOR_ONE = {1'b1, {F{1'b0}}};

    typedef logic [2:0][CW-1:0] vec_t;

    vec_t              p_reg, p_next;
    vec_t              older_reg, older_next;
    vec_t              newer_reg, newer_next;
    vec_t              start_reg, start_next;
    logic [1:0]        seen_reg, seen_next;
    vec_t              d_reg, d_next;
    logic [SSW-1:0]    s_reg, s_next;
    logic [RW-1:0]     root_reg, root_next;
    logic [RMW-1:0]    rrem_reg, rrem_next;
    logic [2:0][DRW-1:0] drem_reg, drem_next;
    logic [2:0][F:0]   lo_reg, lo_next;

    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    vec_t              pos_reg, pos_next;
    logic [2:0][F:0]   col_reg, col_next;
    logic              last_reg, last_next;

    vec_t              in_vec;
    vec_t              a_sel;
    logic [CW-1:0]     d_pick;
    logic [2*SW-1:0]   sq;

    assign in_vec = {z, y, x};

    // first operand of the difference, the second is always the new point
    always_comb
    begin
        unique case (cmd.job)
            JOB_FWD:   a_sel = (seen_reg == SEEN_ONE) ? newer_reg : older_reg;
            JOB_END:   a_sel = newer_reg;
            JOB_FIBER: a_sel = start_reg;
            default:   a_sel = start_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.sq_sel)
            2'd0:    d_pick = d_reg[0];
            2'd1:    d_pick = d_reg[1];
            default: d_pick = d_reg[2];
        endcase
    end

    assign sq = d_pick[SW-1:0] * d_pick[SW-1:0];

    // fiber bookkeeping
    always_comb
    begin
        p_next     = p_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        start_next = start_reg;
        seen_next  = seen_reg;
        if (cmd.accept)
            p_next = in_vec;
        if (cmd.accept && first_point)
        begin
            start_next = in_vec;
            newer_next = in_vec;
            older_next = '0;
            seen_next  = last_point ? SEEN_NONE : SEEN_ONE;
        end
        else if (cmd.finish)
        begin
            if (cmd.job == JOB_FIBER)
                seen_next = SEEN_NONE;
            else
            begin
                older_next = newer_reg;
                newer_next = p_reg;
                seen_next  = SEEN_MANY;
            end
        end
    end

    // absolute differences, scaling and sum of squares
    always_comb
    begin
        logic [CW:0] diff;
        d_next = d_reg;
        s_next = s_reg;
        diff   = '0;
        for (int i = 0; i < 3; i++)
        begin
            diff = {a_sel[i][CW-1], a_sel[i]} - {p_reg[i][CW-1], p_reg[i]};
            if (cmd.diff)
                d_next[i] = diff[CW] ? CW'(-diff) : diff[CW-1:0];
            else if (cmd.shift)
                d_next[i] = d_reg[i] >> 1;
        end
        if (cmd.diff)
            s_next = '0;
        else if (cmd.sq_step)
            s_next = s_reg + {2'b00, sq};
        else if (cmd.rt_step)
            s_next = {s_reg[SSW-3:0], 2'b00};
    end

    // square root, one result bit a cycle
    always_comb
    begin
        logic [RW+3:0] cur;
        logic [RW+3:0] trial;
        logic [RW+3:0] rest;
        cur       = {rrem_reg, s_reg[SSW-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        rest      = cur - trial;
        root_next = root_reg;
        rrem_next = rrem_reg;
        if (cmd.rt_init)
        begin
            root_next = '0;
            rrem_next = '0;
        end
        else if (cmd.rt_step)
        begin
            if (cur >= trial)
            begin
                rrem_next = rest[RMW-1:0];
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rrem_next = cur[RMW-1:0];
                root_next = {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    // three restoring divider lanes sharing the root as divisor
    always_comb
    begin
        logic [NW-1:0]  num;
        logic [DRW:0]   cur;
        logic [DRW:0]   rz;
        logic [DRW:0]   rest;
        drem_next = drem_reg;
        lo_next   = lo_reg;
        num       = '0;
        cur       = '0;
        rest      = '0;
        rz        = {{(DRW + 1 - RW){1'b0}}, root_reg};
        for (int i = 0; i < 3; i++)
        begin
            num  = {1'b0, d_reg[i][SW-1:0], {F{1'b0}}} + NW'(root_reg >> 1);
            cur  = {drem_reg[i], lo_reg[i][F]};
            rest = cur - rz;
            if (cmd.dv_init)
            begin
                drem_next[i] = DRW'(num[NW-1:F+1]);
                lo_next[i]   = num[F:0];
            end
            else if (cmd.dv_step)
            begin
                if (cur >= rz)
                begin
                    drem_next[i] = rest[DRW-1:0];
                    lo_next[i]   = {lo_reg[i][F-1:0], 1'b1};
                end
                else
                begin
                    drem_next[i] = cur[DRW-1:0];
                    lo_next[i]   = {lo_reg[i][F-1:0], 1'b0};
                end
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        col_next       = col_reg;
        last_next      = last_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = (cmd.job == JOB_FIBER);
            last_next      = cmd.res_last;
            unique case (cmd.job)
                JOB_FWD:   pos_next = newer_reg;
                JOB_END:   pos_next = p_reg;
                default:   pos_next = '0;
            endcase
            for (int i = 0; i < 3; i++)
            begin
                if (root_reg == '0)
                    col_next[i] = '0;
                else if (lo_reg[i] > COLOR_ONE)
                    col_next[i] = COLOR_ONE;
                else
                    col_next[i] = lo_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= SEEN_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        older_reg <= older_next;
        newer_reg <= newer_next;
        start_reg <= start_next;
        d_reg     <= d_next;
        s_reg     <= s_next;
        root_reg  <= root_next;
        rrem_reg  <= rrem_next;
        drem_reg  <= drem_next;
        lo_reg    <= lo_next;
        kind_reg  <= kind_next;
        pos_reg   <= pos_next;
        col_reg   <= col_next;
        last_reg  <= last_next;
    end

    always_comb
    begin
        stat           = '0;
        stat.seen_zero = (seen_reg == SEEN_NONE);
        stat.out_free  = !out_valid_reg || !out_stall;
        stat.big       = ((d_reg[0] >> FDC_MAG_LIMIT) != '0) ||
                         ((d_reg[1] >> FDC_MAG_LIMIT) != '0) ||
                         ((d_reg[2] >> FDC_MAG_LIMIT) != '0);
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign pos_x     = pos_reg[0];
    assign pos_y     = pos_reg[1];
    assign pos_z     = pos_reg[2];
    assign red       = col_reg[0];
    assign green     = col_reg[1];
    assign blue      = col_reg[2];
    assign last      = last_reg;

endmodule

### hw/rtl/fiber_direction_colorizer_core.sv
// fiber direction colorizer top level, joins fdc_ctrl and fdc_dp; depends on fdc_pkg
// color pass: difference, scaling shifts, sum of squares, root bits, divider set-up,
// quotient bits, emit; scaling shifts are needed only above COORD_WIDTH 30
// input stalled during each pass; an inner point runs one pass, a last point three
// (vertex, end, fiber), first or stray points none; serial root and divider lanes set the pass
// next item taken once the last result is in the output register; rst_n async low: all empty
module fiber_direction_colorizer_core
    import fdc_pkg::*;
#(
    parameter int COORD_WIDTH     = FDC_COORD_WIDTH,
    parameter int COLOR_FRAC_BITS = FDC_COLOR_FRAC_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // point items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_WIDTH-1:0]     x,
    input  logic signed [COORD_WIDTH-1:0]     y,
    input  logic signed [COORD_WIDTH-1:0]     z,
    input  logic                              first_point,
    input  logic                              last_point,
    // colored vertex and fiber color items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              kind,
    output logic signed [COORD_WIDTH-1:0]     pos_x,
    output logic signed [COORD_WIDTH-1:0]     pos_y,
    output logic signed [COORD_WIDTH-1:0]     pos_z,
    output logic        [COLOR_FRAC_BITS:0]   red,
    output logic        [COLOR_FRAC_BITS:0]   green,
    output logic        [COLOR_FRAC_BITS:0]   blue,
    output logic                              last
);

    // full-scale color, 1.0 in the output format
    localparam logic [COLOR_FRAC_BITS:0] COLOR_ONE = {1'b1, {COLOR_FRAC_BITS{1'b0}}};

    fdc_cmd_t  cmd;
    fdc_stat_t stat;

    // sequencer: accepts points, walks each color pass through its steps
    fdc_ctrl #(
        .COORD_WIDTH     (COORD_WIDTH),
        .COLOR_FRAC_BITS (COLOR_FRAC_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .first_point (first_point),
        .last_point  (last_point),
        .in_stall    (in_stall),
        .stat        (stat),
        .cmd         (cmd)
    );

    // fiber state, shared arithmetic and the output register
    fdc_dp #(
        .COORD_WIDTH     (COORD_WIDTH),
        .COLOR_FRAC_BITS (COLOR_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .x           (x),
        .y           (y),
        .z           (z),
        .first_point (first_point),
        .last_point  (last_point),
        .cmd         (cmd),
        .stat        (stat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last        (last)
    );

    // a result is never written over one that is still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid && out_stall))
        else $error("result loaded while output register held");

    // the fiber color closes its item and carries no position
    a_fiber_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> (last && pos_x == '0 && pos_y == '0 && pos_z == '0))
        else $error("fiber color item malformed");

    // colors stay within full scale
    a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red <= COLOR_ONE && green <= COLOR_ONE && blue <= COLOR_ONE))
        else $error("color above full scale");

    // no item is taken while a color pass is under way
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.diff |-> in_stall)
        else $error("input taken during a color pass");

endmodule
